// ===== design/bba_pkg.sv =====
// Shared constants and controller/datapath interface types for the buddy allocator.
package bba_pkg;

  localparam int DEF_LEVELS = 10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR = 2'd3;

  localparam logic [2:0] WM_NONE    = 3'd0;
  localparam logic [2:0] WM_CLR_I   = 3'd1;
  localparam logic [2:0] WM_SET_I1  = 3'd2;
  localparam logic [2:0] WM_CLR_BUD = 3'd3;
  localparam logic [2:0] WM_SET_I   = 3'd4;

  typedef struct packed {
    logic       load;
    logic       sweep;
    logic       a_init;
    logic       next_row;
    logic       next_lvl;
    logic       take;
    logic       split;
    logic       merge_init;
    logic       merge_step;
    logic [2:0] wmode;
    logic       rec_wr;
    logic       rec_clr;
    logic       res;
    logic [1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic bad_size;
    logic row_hit;
    logic last_row;
    logic d_zero;
    logic need_split;
    logic free_bad;
    logic buddy_free;
  } dp_sts_t;

endpackage

// ===== design/bba_datapath.sv =====
// Datapath: free-tree row memory, block record memory, walk registers and result registers.
module bba_datapath #(
  parameter int LEVELS = bba_pkg::DEF_LEVELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_in,
  input  logic [LEVELS:0]   size_in,
  input  logic [LEVELS-1:0] addr_in,
  input  bba_pkg::dp_cmd_t  cmd,
  output bba_pkg::dp_sts_t  sts,
  output logic              res_valid,
  output logic [1:0]        res_status,
  output logic [LEVELS-1:0] res_address,
  output logic [LEVELS:0]   res_size
);
  import bba_pkg::*;

  localparam int IW   = LEVELS - 1;
  localparam int DW   = $clog2(LEVELS);
  localparam int KW   = $clog2(LEVELS + 1);
  localparam int COLW = (IW < 5) ? IW : 5;
  localparam int COLN = 2 ** COLW;
  localparam int RB   = IW - COLW;
  localparam int AW   = DW + RB;
  localparam int TDEP = 2 ** AW;
  localparam int GRAN = 2 ** IW;
  localparam int SWB  = (AW > IW) ? AW : IW;
  localparam int SWW  = SWB + 1;
  localparam int POOL = 2 ** LEVELS;

  logic              op_r;
  logic [LEVELS:0]   req_r;
  logic [LEVELS-1:0] addr_r;
  logic [KW-1:0]     k_r, k_nxt;
  logic [DW-1:0]     d_r, d_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [SWW-1:0]    swp_r;
  logic [COLN-1:0]   tree_q_r;
  logic [KW-1:0]     rec_q_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [LEVELS-1:0] out_addr_r;
  logic [LEVELS:0]   out_size_r;

  logic [COLN-1:0]   tree_mem [TDEP];
  logic [KW-1:0]     rec_mem  [GRAN];

  logic [KW-1:0]     k_req;
  logic [KW-1:0]     tgt_k;
  logic [DW-1:0]     tgt;
  logic [COLW-1:0]   col;
  logic [COLW-1:0]   hit_col;
  logic [IW:0]       lvl_cnt;
  logic [IW-1:0]     last_idx;
  logic [AW-1:0]     t_addr;
  logic              t_we;
  logic [COLN-1:0]   t_wd;
  logic [IW-1:0]     r_addr;
  logic              r_we;
  logic [KW-1:0]     r_wd;
  logic [LEVELS-1:0] blk_addr;
  logic [KW-1:0]     fk_lvl;

  function automatic logic [KW-1:0] size_level(input logic [LEVELS:0] sz);
    logic [LEVELS:0] m;
    logic [KW-1:0]   k;
    m = sz - 1'b1;
    k = KW'(1);
    for (int b = 1; b < LEVELS; b++) begin
      if (m[b]) k = KW'(b + 1);
    end
    return k;
  endfunction

  function automatic logic [COLW-1:0] low_one(input logic [COLN-1:0] v);
    logic [COLW-1:0] p;
    p = '0;
    for (int b = COLN - 1; b >= 0; b--) begin
      if (v[b]) p = COLW'(b);
    end
    return p;
  endfunction

  assign k_req    = size_level(req_r);
  assign tgt_k    = KW'(LEVELS) - k_r;
  assign tgt      = DW'(tgt_k);
  assign fk_lvl   = KW'(LEVELS) - rec_q_r;
  assign col      = COLW'(i_r);
  assign hit_col  = low_one(tree_q_r);
  assign lvl_cnt  = (IW + 1)'(1) << d_r;
  assign last_idx = IW'(lvl_cnt - 1'b1);
  assign blk_addr = LEVELS'(i_r) << k_r;

  assign sts.sweep_done = swp_r[SWB];
  assign sts.bad_size   = (req_r == '0) || (req_r > (LEVELS + 1)'(POOL));
  assign sts.row_hit    = |tree_q_r;
  assign sts.last_row   = (i_r >> COLW) == (last_idx >> COLW);
  assign sts.d_zero     = (d_r == '0);
  assign sts.need_split = (d_r < tgt);
  assign sts.free_bad   = addr_r[0] || (rec_q_r == '0) || (rec_q_r > KW'(LEVELS));
  assign sts.buddy_free = tree_q_r[col ^ COLW'(1)];

  always_comb begin
    t_addr = cmd.sweep ? AW'(swp_r) : ((AW'(d_r) << RB) | AW'(i_r >> COLW));
    t_we   = cmd.sweep;
    t_wd   = (t_addr == '0) ? COLN'(1) : '0;
    if (!cmd.sweep) begin
      t_we = 1'b1;
      unique case (cmd.wmode)
        WM_CLR_I:   t_wd = tree_q_r & ~(COLN'(1) << col);
        WM_SET_I1:  t_wd = tree_q_r | (COLN'(1) << (col | COLW'(1)));
        WM_CLR_BUD: t_wd = tree_q_r & ~(COLN'(1) << (col ^ COLW'(1)));
        WM_SET_I:   t_wd = tree_q_r | (COLN'(1) << col);
        default: begin
          t_we = 1'b0;
          t_wd = tree_q_r;
        end
      endcase
    end
  end

  always_comb begin
    if (cmd.sweep) begin
      r_addr = IW'(swp_r);
    end else if (op_r == OP_FREE) begin
      r_addr = addr_r[LEVELS-1:1];
    end else begin
      r_addr = blk_addr[LEVELS-1:1];
    end
    r_we = cmd.sweep || cmd.rec_wr || cmd.rec_clr;
    r_wd = cmd.rec_wr ? k_r : '0;
  end

  always_ff @(posedge clk) begin
    if (t_we) tree_mem[t_addr] <= t_wd;
    tree_q_r <= tree_mem[t_addr];
  end

  always_ff @(posedge clk) begin
    if (r_we) rec_mem[r_addr] <= r_wd;
    rec_q_r <= rec_mem[r_addr];
  end

  always_comb begin
    d_nxt = d_r;
    i_nxt = i_r;
    k_nxt = k_r;
    priority if (cmd.a_init) begin
      k_nxt = k_req;
      d_nxt = DW'(KW'(LEVELS) - k_req);
      i_nxt = '0;
    end else if (cmd.next_row) begin
      i_nxt = i_r + IW'(COLN);
    end else if (cmd.next_lvl) begin
      d_nxt = d_r - 1'b1;
      i_nxt = '0;
    end else if (cmd.take) begin
      i_nxt = i_r | IW'(hit_col);
    end else if (cmd.split) begin
      d_nxt = d_r + 1'b1;
      i_nxt = i_r << 1;
    end else if (cmd.merge_init) begin
      k_nxt = rec_q_r;
      d_nxt = DW'(fk_lvl);
      i_nxt = IW'(addr_r >> rec_q_r);
    end else if (cmd.merge_step) begin
      d_nxt = d_r - 1'b1;
      i_nxt = i_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    i_r <= i_nxt;
    k_r <= k_nxt;
    if (cmd.load) begin
      op_r   <= op_in;
      req_r  <= size_in;
      addr_r <= addr_in;
    end
    if (cmd.res) begin
      out_status_r <= cmd.res_status;
      if (cmd.res_status == ST_OK) begin
        out_addr_r <= (op_r == OP_FREE) ? addr_r : blk_addr;
        out_size_r <= (LEVELS + 1)'(1) << k_r;
      end else begin
        out_addr_r <= '0;
        out_size_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep) swp_r <= swp_r + 1'b1;
      out_valid_r <= cmd.res;
    end
  end

  assign res_valid   = out_valid_r;
  assign res_status  = out_status_r;
  assign res_address = out_addr_r;
  assign res_size    = out_size_r;

endmodule

// ===== design/bba_ctrl.sv =====
// Controller: sequences clearing, level search, splitting and merging.
module bba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             op_in,
  input  bba_pkg::dp_sts_t sts,
  output bba_pkg::dp_cmd_t cmd,
  output logic             busy
);
  import bba_pkg::*;

  localparam logic [3:0] S_CLR       = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_A_INIT    = 4'd2;
  localparam logic [3:0] S_A_RD      = 4'd3;
  localparam logic [3:0] S_A_CHK     = 4'd4;
  localparam logic [3:0] S_A_TAKE    = 4'd5;
  localparam logic [3:0] S_A_SPL_RD  = 4'd6;
  localparam logic [3:0] S_A_SPL_WR  = 4'd7;
  localparam logic [3:0] S_A_REC     = 4'd8;
  localparam logic [3:0] S_F_RD      = 4'd9;
  localparam logic [3:0] S_F_CHK     = 4'd10;
  localparam logic [3:0] S_F_MRG_RD  = 4'd11;
  localparam logic [3:0] S_F_MRG_CHK = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (sts.sweep_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.sweep = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (op_in == OP_FREE) ? S_F_RD : S_A_INIT;
        end
      end
      S_A_INIT: begin
        if (sts.bad_size) begin
          cmd.res        = 1'b1;
          cmd.res_status = ST_BAD_SIZE;
          state_nxt      = S_IDLE;
        end else begin
          cmd.a_init = 1'b1;
          state_nxt  = S_A_RD;
        end
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (sts.row_hit) begin
          cmd.take  = 1'b1;
          state_nxt = S_A_TAKE;
        end else if (!sts.last_row) begin
          cmd.next_row = 1'b1;
          state_nxt    = S_A_RD;
        end else if (!sts.d_zero) begin
          cmd.next_lvl = 1'b1;
          state_nxt    = S_A_RD;
        end else begin
          cmd.res        = 1'b1;
          cmd.res_status = ST_NO_BLOCK;
          state_nxt      = S_IDLE;
        end
      end
      S_A_TAKE, S_A_SPL_WR: begin
        cmd.wmode = (state_r == S_A_TAKE) ? WM_CLR_I : WM_SET_I1;
        if (sts.need_split) begin
          cmd.split = 1'b1;
          state_nxt = S_A_SPL_RD;
        end else begin
          state_nxt = S_A_REC;
        end
      end
      S_A_SPL_RD: state_nxt = S_A_SPL_WR;
      S_A_REC: begin
        cmd.rec_wr     = 1'b1;
        cmd.res        = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_IDLE;
      end
      S_F_RD: state_nxt = S_F_CHK;
      S_F_CHK: begin
        if (sts.free_bad) begin
          cmd.res        = 1'b1;
          cmd.res_status = ST_BAD_ADDR;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rec_clr    = 1'b1;
          cmd.merge_init = 1'b1;
          state_nxt      = S_F_MRG_RD;
        end
      end
      S_F_MRG_RD: state_nxt = S_F_MRG_CHK;
      S_F_MRG_CHK: begin
        if (!sts.d_zero && sts.buddy_free) begin
          cmd.wmode      = WM_CLR_BUD;
          cmd.merge_step = 1'b1;
          state_nxt      = S_F_MRG_RD;
        end else begin
          cmd.wmode      = WM_SET_I;
          cmd.res        = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res |=> (state_r == S_IDLE))
    else $error("result issued without returning to idle");
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!cmd.res && !cmd.load))
    else $error("activity during clearing pass");
  a_no_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep |-> (cmd.wmode == WM_NONE && !cmd.rec_wr && !cmd.rec_clr))
    else $error("memory write collides with clearing pass");
`endif

endmodule

// ===== design/buddy_block_allocator.sv =====
// Buddy allocator top level: controller plus datapath.
// After reset the block clears its memories, with busy high. An allocate scans the free tree
// in 32-node rows during the level search (up to 36 rows at the default size), then splits
// the found block level by level; a free merges with free buddies level by level. Each
// request yields one result beat on out_valid in the same cycle that busy drops; start is
// taken whenever busy is low, and the result must be captured in that cycle since it is
// shown once.
module buddy_block_allocator #(
  parameter int LEVELS = bba_pkg::DEF_LEVELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [LEVELS:0]   in_request_size,
  input  logic [LEVELS-1:0] in_free_address,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [LEVELS-1:0] out_block_address,
  output logic [LEVELS:0]   out_block_size
);
  import bba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    accept;

  assign accept = start && !busy;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .op_in (in_operation),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bba_datapath #(.LEVELS(LEVELS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .op_in       (in_operation),
    .size_in     (in_request_size),
    .addr_in     (in_free_address),
    .cmd         (cmd),
    .sts         (sts),
    .res_valid   (out_valid),
    .res_status  (out_status),
    .res_address (out_block_address),
    .res_size    (out_block_size)
  );

endmodule
